@@ rtl/rmeu_pkg.sv @@
`default_nettype none
package rmeu_pkg;

  localparam int RegCount = 8;
  localparam int MemWords = 1024;
  localparam int RegAw = $clog2(RegCount);
  localparam int MemAw = $clog2(MemWords);

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_MOV = 4'd3;
  localparam logic [3:0] OP_LOD = 4'd4;
  localparam logic [3:0] OP_STR = 4'd5;
  localparam logic [3:0] OP_JMP = 4'd6;
  localparam logic [3:0] OP_BEQ = 4'd7;
  localparam logic [3:0] OP_BLT = 4'd8;
  localparam logic [3:0] OP_RDN = 4'd9;
  localparam logic [3:0] OP_PTN = 4'd10;
  localparam logic [3:0] OP_HLT = 4'd11;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ILLEGAL  = 3'd1;
  localparam logic [2:0] ST_ADDR     = 3'd2;
  localparam logic [2:0] ST_NEGJUMP  = 3'd3;
  localparam logic [2:0] ST_UNKNOWN  = 3'd4;
  localparam logic [2:0] ST_BADINPUT = 3'd5;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] first_operand;
    logic signed [31:0] second_operand;
    logic signed [31:0] third_operand;
    logic signed [31:0] read_value;
  } in_req_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        print_valid;
    logic [31:0] print_value;
    logic        halted;
    logic [31:0] halt_code;
    logic [2:0]  status;
  } out_req_t;

  // True when a 32-bit operand names an existing register.
  function automatic logic reg_ok(input logic [31:0] r);
    reg_ok = (r < 32'(RegCount));
  endfunction

  function automatic logic addr_ok(input logic [31:0] a);
    addr_ok = (a < 32'(MemWords));
  endfunction

endpackage
`default_nettype wire

@@ rtl/rmeu_ram.sv @@
`default_nettype none
module rmeu_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/register_machine_execute_unit_top.sv @@
`default_nettype none
// Executes one decoded register-machine instruction per request and returns one
// result request for each. The first stage does the register-file lookup and
// checks and registers the decoded fields; the second stage reads the data
// memory (registered) for a load, writes back and forms the result. A new
// instruction is accepted only after the previous one has left stage two, and
// stage two waits while the output register holds a result that is not taken.
// After reset the block sweeps all 1024 words of the data memory to zero, one
// word per cycle, and accepts no request until then. A halt or any error stops
// the machine; later requests get halted results until the next reset.
module register_machine_execute_unit_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rmeu_pkg::in_req_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rmeu_pkg::out_req_t     out_data
);

  localparam int RegAw = rmeu_pkg::RegAw;
  localparam int MemAw = rmeu_pkg::MemAw;

  // Register file is small, kept in flops with reset.
  logic [31:0] rf_r [rmeu_pkg::RegCount];

  logic             clr_r;
  logic [MemAw:0]   clr_cnt_r;
  logic             busy_r;     // stage two holds an instruction
  logic [31:0]      pc_r;
  logic             stopped_r;

  // Stage-two registers.
  logic [3:0]       cmd_r;
  logic [2:0]       st_r;
  logic [RegAw-1:0] dst_r;
  logic [31:0]      a_r, b_r, imm_r, tgt_r;
  logic             stop_r;
  logic [MemAw-1:0] laddr_r;

  // Decode in stage one.
  rmeu_pkg::in_req_t d;
  logic [31:0] o1, o2, o3;
  logic        ok1, ok2, ok3;
  logic [31:0] r1, r2, r3, sum_l, sum_s, sum_j;
  logic [2:0]  st;
  logic [31:0] pa, pb, pimm;
  logic [MemAw-1:0] maddr;
  logic [MemAw-1:0] raddr;
  logic        mwe;
  logic [31:0] mwdata;

  logic        accept, issue;
  logic [31:0] mem_rd;

  assign d   = in_data;
  assign o1  = d.first_operand;
  assign o2  = d.second_operand;
  assign o3  = d.third_operand;
  assign ok1 = rmeu_pkg::reg_ok(o1);
  assign ok2 = rmeu_pkg::reg_ok(o2);
  assign ok3 = rmeu_pkg::reg_ok(o3);
  assign r1  = rf_r[o1[RegAw-1:0]];
  assign r2  = rf_r[o2[RegAw-1:0]];
  assign r3  = rf_r[o3[RegAw-1:0]];
  assign sum_l = r2 + o3;
  assign sum_s = r1 + o2;
  assign sum_j = sum_s;

  // The output register frees when its result is taken; stage two only
  // retires into an empty or draining output register.
  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = !clr_r && !busy_r;
  assign accept   = in_valid && in_ready;
  assign issue    = busy_r && out_free;

  always_comb begin
    st    = rmeu_pkg::ST_OK;
    pa    = r2;
    pb    = r3;
    pimm  = o2;
    maddr = sum_l[MemAw-1:0];
    mwe   = 1'b0;
    mwdata = r3;
    if (!stopped_r) begin
      unique case (d.command)
        rmeu_pkg::OP_ADD, rmeu_pkg::OP_SUB, rmeu_pkg::OP_MUL: begin
          if (!ok1 || !ok2 || !ok3) st = rmeu_pkg::ST_ILLEGAL;
        end
        rmeu_pkg::OP_MOV: begin
          if (!ok1 || o2[31]) st = rmeu_pkg::ST_ILLEGAL;
        end
        rmeu_pkg::OP_LOD: begin
          if (!ok1 || !ok2) st = rmeu_pkg::ST_ILLEGAL;
          else if (!rmeu_pkg::addr_ok(sum_l)) st = rmeu_pkg::ST_ADDR;
        end
        rmeu_pkg::OP_STR: begin
          maddr = sum_s[MemAw-1:0];
          if (!ok1 || !ok3) st = rmeu_pkg::ST_ILLEGAL;
          else if (!rmeu_pkg::addr_ok(sum_s)) st = rmeu_pkg::ST_ADDR;
          else mwe = accept;
        end
        rmeu_pkg::OP_JMP: begin
          pimm = sum_j;
          if (!ok1) st = rmeu_pkg::ST_ILLEGAL;
          else if (sum_j[31]) st = rmeu_pkg::ST_NEGJUMP;
        end
        rmeu_pkg::OP_BEQ, rmeu_pkg::OP_BLT: begin
          pa = r1;
          pb = r2;
          if (!ok1 || !ok2 || o3[31]) st = rmeu_pkg::ST_ILLEGAL;
        end
        rmeu_pkg::OP_RDN: begin
          pimm = d.read_value;
          if (!ok1) st = rmeu_pkg::ST_ILLEGAL;
          else if (d.read_value[31]) st = rmeu_pkg::ST_BADINPUT;
        end
        rmeu_pkg::OP_PTN, rmeu_pkg::OP_HLT: begin
          pa = r1;
          if (!ok1) st = rmeu_pkg::ST_ILLEGAL;
        end
        default: st = rmeu_pkg::ST_UNKNOWN;
      endcase
    end
    if (clr_r) begin
      maddr  = clr_cnt_r[MemAw-1:0];
      mwe    = 1'b1;
      mwdata = '0;
    end
  end

  // While stage two holds a load, the read address stays on that load so the
  // memory output survives a stalled result.
  assign raddr = busy_r ? laddr_r : maddr;

  rmeu_ram #(.Width(32), .Depth(rmeu_pkg::MemWords)) u_dmem (
    .clk   (clk),
    .we    (mwe),
    .waddr (maddr),
    .wdata (mwdata),
    .raddr (raddr),
    .rdata (mem_rd)
  );

  // Stage two: write back and build the result.
  rmeu_pkg::out_req_t res;
  logic        wb;
  logic [31:0] wb_val;
  logic [63:0] prod;
  assign prod = 64'(a_r) * 64'(b_r);

  always_comb begin
    res = '0;
    res.next_pc = pc_r + 32'd1;
    wb     = 1'b0;
    wb_val = '0;
    if (stop_r) begin
      res.next_pc = pc_r;
      res.halted  = 1'b1;
    end else if (st_r != rmeu_pkg::ST_OK) begin
      res.next_pc = pc_r;
      res.halted  = 1'b1;
      res.status  = st_r;
    end else begin
      unique case (cmd_r)
        rmeu_pkg::OP_ADD: begin wb = 1'b1; wb_val = a_r + b_r; end
        rmeu_pkg::OP_SUB: begin wb = 1'b1; wb_val = (b_r > a_r) ? '0 : a_r - b_r; end
        rmeu_pkg::OP_MUL: begin wb = 1'b1; wb_val = prod[31:0]; end
        rmeu_pkg::OP_MOV, rmeu_pkg::OP_RDN: begin wb = 1'b1; wb_val = imm_r; end
        rmeu_pkg::OP_LOD: begin wb = 1'b1; wb_val = mem_rd; end
        rmeu_pkg::OP_JMP: res.next_pc = imm_r;
        rmeu_pkg::OP_BEQ: if (a_r == b_r) res.next_pc = tgt_r;
        rmeu_pkg::OP_BLT: if (a_r < b_r) res.next_pc = tgt_r;
        rmeu_pkg::OP_PTN: begin
          res.print_valid = 1'b1;
          res.print_value = a_r;
        end
        rmeu_pkg::OP_HLT: begin
          res.next_pc   = pc_r;
          res.halted    = 1'b1;
          res.halt_code = a_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      busy_r    <= 1'b0;
      out_valid <= 1'b0;
      pc_r      <= '0;
      stopped_r <= 1'b0;
      for (int i = 0; i < rmeu_pkg::RegCount; i++) rf_r[i] <= '0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == (MemAw+1)'(rmeu_pkg::MemWords - 1)) clr_r <= 1'b0;
      end
      if (issue) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        busy_r  <= 1'b1;
        cmd_r   <= d.command;
        st_r    <= st;
        stop_r  <= stopped_r;
        dst_r   <= o1[RegAw-1:0];
        a_r     <= pa;
        b_r     <= pb;
        imm_r   <= pimm;
        tgt_r   <= o3;
        laddr_r <= maddr;
      end
      if (issue) begin
        busy_r    <= 1'b0;
        out_data  <= res;
        pc_r      <= res.next_pc;
        if (res.halted) stopped_r <= 1'b1;
        if (wb) rf_r[dst_r] <= wb_val;
      end
    end
  end

endmodule
`default_nettype wire
